/* src/scm_pkg.sv */
`timescale 1ns / 1ps
// scm_pkg: shared codes for the scanset class matcher
// holds character constants, status codes, parse and scan phase codes; no dependencies

package scm_pkg;

	// characters that the format grammar looks for
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_CARET   = 8'h5E;
	localparam logic [7:0] CH_RBRACK  = 8'h5D;
	localparam logic [7:0] CH_DASH    = 8'h2D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_NUL     = 8'h00;

	// status codes reported on the result channel
	localparam logic [3:0] ST_OK          = 4'd0;
	localparam logic [3:0] ST_NO_PERCENT  = 4'd1;
	localparam logic [3:0] ST_NO_NUMBER   = 4'd2;
	localparam logic [3:0] ST_NO_BRACKET  = 4'd3;
	localparam logic [3:0] ST_ZERO_WIDTH  = 4'd4;
	localparam logic [3:0] ST_TOO_LONG    = 4'd5;
	localparam logic [3:0] ST_RANGE_START = 4'd6;
	localparam logic [3:0] ST_RANGE_BACK  = 4'd7;
	localparam logic [3:0] ST_NO_CLOSE    = 4'd8;

	// format parser phases
	localparam logic [3:0] PH_PERCENT    = 4'd0;
	localparam logic [3:0] PH_FIRSTDIG   = 4'd1;
	localparam logic [3:0] PH_DIGITS     = 4'd2;
	localparam logic [3:0] PH_SETSTART   = 4'd3;
	localparam logic [3:0] PH_AFTERCARET = 4'd4;
	localparam logic [3:0] PH_AFTERRBR   = 4'd5;
	localparam logic [3:0] PH_BODY       = 4'd6;
	localparam logic [3:0] PH_RANGEEND   = 4'd7;
	localparam logic [3:0] PH_FAILED     = 4'd8;
	localparam logic [3:0] PH_END        = 4'd9;

	// source scan phases
	localparam logic [1:0] SC_FIRST   = 2'd0;
	localparam logic [1:0] SC_COPYING = 2'd1;
	localparam logic [1:0] SC_STOPPED = 2'd2;

	localparam int TABLE_ENTRIES = 256;

	typedef logic [TABLE_ENTRIES-1:0] keep_vec_t;

endpackage

/* src/scanset_class_matcher_core.sv */
`timescale 1ns / 1ps
// scanset_class_matcher_core: builds a keep table from a %<width>[set] format, filters source bytes
// depends on scm_pkg
//
// an accepted request reaches its result through the input register and the result register
// throughput: one request per cycle if unstalled; every byte, range fills too, is combinational
// reset: arst_n clears the keep table, parser, scan state and both valid flags at once
// the keep table is a 256-bit flop vector, so no clearing pass follows reset

module scanset_class_matcher_core import scm_pkg::*; #(
	parameter int MAX_WIDTH = 4095
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       kind,
	input  logic [7:0] char_in,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] status,
	output logic [7:0] out_char,
	output logic       kept,
	output logic       matched,
	output logic       done_res
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int XW = WW + 4;
	localparam logic [XW-1:0] MAX_WIDE = XW'(MAX_WIDTH);

	// input stage
	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// result stage
	logic       valid_s2;
	logic [3:0] status_s2;
	logic [7:0] char_s2;
	logic       kept_s2;
	logic       matched_s2;
	logic       done_s2;

	// block state
	keep_vec_t     tab_q;
	logic          setv_q;
	logic [WW-1:0] width_q;
	logic [3:0]    phase_q;
	logic [7:0]    prev_q;
	logic [3:0]    err_q;
	logic [WW-1:0] count_q;
	logic [1:0]    scan_q;

	// next state and result
	keep_vec_t     tab_d;
	logic          setv_d;
	logic [WW-1:0] width_d;
	logic [3:0]    phase_d;
	logic [7:0]    prev_d;
	logic [3:0]    err_d;
	logic [WW-1:0] count_d;
	logic [1:0]    scan_d;
	logic [3:0]    r_status;
	logic [7:0]    r_char;
	logic          r_kept;
	logic          r_matched;
	logic          r_done;

	logic          adv;
	logic          is_digit;
	logic [XW-1:0] digit_x;
	logic [XW-1:0] wide_x;
	logic          lit_rbr;
	logic          lit_dash;
	logic          in_body;
	logic [WW-1:0] count_inc;

	// handshake: s1 moves on when the result register is free or being drained
	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;

	assign is_digit  = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
	assign digit_x   = XW'(char_s1[3:0]);
	assign count_inc = count_q + WW'(1);

	// width accumulate: width * 10 + digit, saturated
	always_comb begin
		wide_x = XW'({width_q, 3'b000}) + XW'({width_q, 1'b0}) + digit_x;
	end

	// one-byte step of parser and scanner
	always_comb begin
		tab_d     = tab_q;
		setv_d    = setv_q;
		width_d   = width_q;
		phase_d   = phase_q;
		prev_d    = prev_q;
		err_d     = err_q;
		count_d   = count_q;
		scan_d    = scan_q;
		r_status  = ST_OK;
		r_char    = 8'h00;
		r_kept    = 1'b0;
		r_matched = 1'b0;
		r_done    = 1'b0;
		lit_rbr   = 1'b0;
		lit_dash  = 1'b0;
		in_body   = 1'b0;

		if (!kind_s1) begin
			// a new format after the previous one ended
			if (phase_q == PH_END) begin
				phase_d = PH_PERCENT;
				width_d = '0;
				prev_d  = 8'h00;
				err_d   = ST_OK;
				setv_d  = 1'b1;
				count_d = '0;
				scan_d  = SC_FIRST;
			end
			if (char_s1 != CH_NUL) begin
				case (phase_d)
					PH_PERCENT: begin
						if (char_s1 == CH_PERCENT) begin
							phase_d = PH_FIRSTDIG;
						end else begin
							err_d   = ST_NO_PERCENT;
							phase_d = PH_FAILED;
						end
					end
					PH_FIRSTDIG: begin
						if (is_digit) begin
							width_d = (digit_x > MAX_WIDE) ? WW'(MAX_WIDTH) : WW'(digit_x);
							phase_d = PH_DIGITS;
						end else begin
							err_d   = ST_NO_NUMBER;
							phase_d = PH_FAILED;
						end
					end
					PH_DIGITS: begin
						if (is_digit) begin
							width_d = (wide_x > MAX_WIDE) ? WW'(MAX_WIDTH) : WW'(wide_x);
						end else if (char_s1 == CH_LBRACK) begin
							if (width_d == '0) begin
								err_d   = ST_ZERO_WIDTH;
								phase_d = PH_FAILED;
							end else begin
								tab_d   = '0;
								setv_d  = 1'b1;
								phase_d = PH_SETSTART;
							end
						end else begin
							err_d   = ST_NO_BRACKET;
							phase_d = PH_FAILED;
						end
					end
					PH_SETSTART: begin
						if (char_s1 == CH_CARET) begin
							tab_d    = '1;
							tab_d[0] = 1'b0;
							setv_d   = 1'b0;
							phase_d  = PH_AFTERCARET;
						end else begin
							lit_rbr  = 1'b1;
							lit_dash = 1'b1;
							in_body  = 1'b1;
						end
					end
					PH_AFTERCARET: begin
						lit_rbr  = 1'b1;
						lit_dash = 1'b1;
						in_body  = 1'b1;
					end
					PH_AFTERRBR: begin
						lit_dash = 1'b1;
						in_body  = 1'b1;
					end
					PH_BODY: begin
						in_body = 1'b1;
					end
					PH_RANGEEND: begin
						if (char_s1 <= prev_q) begin
							err_d   = ST_RANGE_BACK;
							phase_d = PH_FAILED;
						end else begin
							for (int i = 0; i < TABLE_ENTRIES; i++) begin
								if ((8'(i) > prev_q) && (8'(i) <= char_s1)) begin
									tab_d[i] = setv_q;
								end
							end
							prev_d  = 8'h00;
							phase_d = PH_BODY;
						end
					end
					default: begin
					end
				endcase

				// set members: leading literals, ranges, plain bytes, closing bracket
				if (in_body) begin
					if (lit_rbr && char_s1 == CH_RBRACK) begin
						tab_d[CH_RBRACK] = setv_d;
						phase_d          = PH_AFTERRBR;
					end else if (lit_dash && char_s1 == CH_DASH) begin
						tab_d[CH_DASH] = setv_d;
						phase_d        = PH_BODY;
					end else if (char_s1 == CH_RBRACK) begin
						if (last_s1) begin
							err_d   = ST_OK;
							phase_d = PH_END;
						end else begin
							err_d   = ST_TOO_LONG;
							phase_d = PH_FAILED;
						end
					end else if (char_s1 == CH_DASH) begin
						if (prev_q == 8'h00) begin
							err_d   = ST_RANGE_START;
							phase_d = PH_FAILED;
						end else begin
							phase_d = PH_RANGEEND;
						end
					end else begin
						tab_d[char_s1] = setv_d;
						prev_d         = char_s1;
						phase_d        = PH_BODY;
					end
				end
			end

			// end of format: the error that the stopping point implies
			if (char_s1 == CH_NUL || last_s1) begin
				case (phase_d)
					PH_PERCENT:  err_d = ST_NO_PERCENT;
					PH_FIRSTDIG: err_d = ST_NO_NUMBER;
					PH_DIGITS:   err_d = ST_NO_BRACKET;
					PH_RANGEEND: err_d = ST_RANGE_BACK;
					PH_FAILED, PH_END: begin
					end
					default:     err_d = ST_NO_CLOSE;
				endcase
				phase_d = PH_END;
			end
			r_status = err_d;
			r_done   = (phase_d == PH_END) || (phase_d == PH_FAILED);
		end else if (phase_q != PH_END || err_q != ST_OK) begin
			// source byte while no good format is in place
			if (phase_q == PH_END || phase_q == PH_FAILED) begin
				r_status = err_q;
				r_done   = 1'b1;
			end
		end else begin
			// source scan against the keep table
			if (scan_q != SC_STOPPED) begin
				if (tab_q[char_s1] && count_q < width_q) begin
					r_kept  = 1'b1;
					r_char  = char_s1;
					count_d = count_inc;
					if (count_inc >= width_q) begin
						scan_d = SC_STOPPED;
						r_done = 1'b1;
					end else begin
						scan_d = SC_COPYING;
					end
				end else begin
					scan_d = SC_STOPPED;
					r_done = 1'b1;
				end
			end else begin
				r_done = 1'b1;
			end
			r_matched = (count_d != '0);
			if (last_s1) begin
				r_done  = 1'b1;
				scan_d  = SC_FIRST;
				count_d = '0;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			char_s1 <= char_in;
			last_s1 <= last;
		end
	end

	// state update, one byte per advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_q   <= '0;
			setv_q  <= 1'b1;
			width_q <= '0;
			phase_q <= PH_PERCENT;
			prev_q  <= 8'h00;
			err_q   <= ST_OK;
			count_q <= '0;
			scan_q  <= SC_FIRST;
		end else if (adv) begin
			tab_q   <= tab_d;
			setv_q  <= setv_d;
			width_q <= width_d;
			phase_q <= phase_d;
			prev_q  <= prev_d;
			err_q   <= err_d;
			count_q <= count_d;
			scan_q  <= scan_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || !out_stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s2  <= r_status;
			char_s2    <= r_char;
			kept_s2    <= r_kept;
			matched_s2 <= r_matched;
			done_s2    <= r_done;
		end
	end

	assign out_valid = valid_s2;
	assign status    = status_s2;
	assign out_char  = char_s2;
	assign kept      = kept_s2;
	assign matched   = matched_s2;
	assign done_res  = done_s2;

endmodule

/* src/scm_checker.sv */
`timescale 1ns / 1ps
// scm_checker: port-level checks for scanset_class_matcher_core, with its bind
// depends on scm_pkg and scanset_class_matcher_core

module scm_checker import scm_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [3:0] status,
	input logic [7:0] out_char,
	input logic       kept,
	input logic       matched,
	input logic       done_res
);

	// a stalled result request stays and holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_char)
			&& $stable(kept) && $stable(matched) && $stable(done_res))
		else $error("stalled result changed");

	// a kept byte comes only from a good format and is never the terminator
	a_kept_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kept |-> status == ST_OK && out_char != CH_NUL)
		else $error("kept byte with error or zero value");

	// a byte that is not kept shows no character
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kept |-> out_char == CH_NUL)
		else $error("dropped byte shows a character");

	// any error is final and carries no match
	a_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> done_res && !matched && !kept
			&& status <= ST_NO_CLOSE)
		else $error("error result malformed");

endmodule

bind scanset_class_matcher_core scm_checker u_scm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.out_char  (out_char),
	.kept      (kept),
	.matched   (matched),
	.done_res  (done_res)
);
